/* rtl/core/aes_pkg.sv */
// aes_pkg: shared types, register codes, S-box tables and round functions
// for the AES block cipher core. No dependencies.
package aes_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned WORD_IDX_W  = 6;
   localparam int unsigned ROW_IDX_W   = 4;
   localparam int unsigned STEP_W      = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd4;

   localparam logic [1:0] KEY_LEN_256 = 2'd2;
   localparam logic [1:0] KEY_LEN_RSVD = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_KEY0,
      ST_ROUND
   } aes_state_type;

   // controller -> datapath
   typedef struct packed {
      logic                  load;
      logic                  dec;
      logic                  exp_init;
      logic                  exp_step;
      logic [WORD_IDX_W-1:0] exp_index;
      logic [ROW_IDX_W-1:0]  rd_row;
      logic                  rnd_en;
      logic [STEP_W-1:0]     step;
   } aes_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic              cfg_written;
      logic [STEP_W-1:0] rounds;
   } aes_status_type;

   localparam logic [7:0] FWD_SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]],
                  FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
   endfunction

   // byte 4c+r of the state sits at bits 127-8(4c+r)
   function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      logic [7:0]   b;
      logic [1:0]   src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? 2'(c + 4 - r) : 2'(c + r);
            b = s[127 - 8 * (4 * src + r) -: 8];
            t[127 - 8 * (4 * c + r) -: 8] = inv ? INV_SBOX[b] : FWD_SBOX[b];
         end
      end
      sub_shift = t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
      logic [127:0]  t;
      logic [7:0]    a [4];
      logic [7:0]    x2 [4];
      logic [7:0]    x4 [4];
      logic [7:0]    x8 [4];
      logic [7:0]    m2 [4];
      logic [7:0]    m3 [4];
      logic [7:0]    m9 [4];
      logic [7:0]    mb [4];
      logic [7:0]    md [4];
      logic [7:0]    me [4];
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = s[127 - 8 * (4 * c + k) -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ a[k];
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
         end
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = inv ?
               (me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4]) :
               (m2[r] ^ m3[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4]);
         end
      end
      mix = t;
   endfunction

endpackage

/* rtl/core/aes_ctrl.sv */
// aes_ctrl: sequencer for key expansion and the round loop.
// Depends on aes_pkg.
module aes_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_decrypt,
   input  aes_pkg::aes_status_type status,
   output aes_pkg::aes_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);

   aes_pkg::aes_state_type state_ff, state_in;
   logic                            ready_ff, ready_in;
   logic                            dec_ff, dec_in;
   logic                            strobe_ff, strobe_in;
   logic [aes_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [aes_pkg::WORD_IDX_W-1:0]  idx_ff, idx_in;
   logic                            accept;
   logic                            exp_last;
   logic                            final_step;
   logic [aes_pkg::STEP_W-1:0]      next_k;
   logic [aes_pkg::WORD_IDX_W-1:0]  last_word;

   assign accept     = start && (state_ff == aes_pkg::ST_IDLE);
   assign last_word  = aes_pkg::WORD_IDX_W'({status.rounds, 2'b11});
   assign exp_last   = (idx_ff == last_word);
   assign final_step = (step_ff == status.rounds);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (accept) state_in = ready_ff ? aes_pkg::ST_KEY0 : aes_pkg::ST_EXPAND;
         end
         aes_pkg::ST_EXPAND: begin
            if (exp_last) state_in = aes_pkg::ST_KEY0;
         end
         aes_pkg::ST_KEY0:  state_in = aes_pkg::ST_ROUND;
         aes_pkg::ST_ROUND: begin
            if (final_step) state_in = aes_pkg::ST_IDLE;
         end
         default: state_in = aes_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd       = '0;
      ready_in  = ready_ff;
      dec_in    = dec_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      next_k    = '0;
      unique case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.load     = 1'b1;
               cmd.exp_init = !ready_ff;
               dec_in       = req_decrypt;
               idx_in       = '0;
            end
         end
         aes_pkg::ST_EXPAND: begin
            cmd.exp_step  = 1'b1;
            cmd.exp_index = idx_ff;
            idx_in        = idx_ff + 1'b1;
            if (exp_last) ready_in = 1'b1;
         end
         aes_pkg::ST_KEY0: begin
            next_k  = '0;
            step_in = '0;
         end
         aes_pkg::ST_ROUND: begin
            next_k     = step_ff + 1'b1;
            cmd.rnd_en = 1'b1;
            step_in    = step_ff + 1'b1;
            strobe_in  = final_step;
         end
         default: ;
      endcase
      cmd.dec    = dec_ff;
      cmd.step   = step_ff;
      cmd.rd_row = dec_ff ? (status.rounds - next_k) : next_k;
      if (status.cfg_written) ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= aes_pkg::ST_IDLE;
         ready_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         step_ff   <= '0;
         idx_ff    <= '0;
         dec_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ready_ff  <= ready_in;
         strobe_ff <= strobe_in;
         step_ff   <= step_in;
         idx_ff    <= idx_in;
         dec_ff    <= dec_in;
      end
   end

   assign busy       = (state_ff != aes_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;

   a_strobe_after_round: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == aes_pkg::ST_ROUND))
      else $error("result strobe without a final round");

   a_keys_before_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aes_pkg::ST_KEY0) |-> ready_ff)
      else $error("rounds started on stale keys");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aes_pkg::ST_ROUND) |-> (step_ff <= status.rounds))
      else $error("round step past last round");

   a_expand_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aes_pkg::ST_EXPAND) |-> (idx_ff <= last_word))
      else $error("key expansion ran past schedule");

endmodule

/* rtl/core/aes_dp.sv */
// aes_dp: key registers, key expansion unit, round key store and round unit.
// Depends on aes_pkg.
module aes_dp #(
   parameter int unsigned ROUND_KEY_WORDS = 60
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [aes_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wdata,
   input  logic [63:0]                     req_block_high,
   input  logic [63:0]                     req_block_low,
   input  aes_pkg::aes_cmd_type            cmd,
   output aes_pkg::aes_status_type         status,
   output logic [63:0]                     rsp_result_high,
   output logic [63:0]                     rsp_result_low
);

   localparam int unsigned ROWS  = (ROUND_KEY_WORDS + 3) / 4;
   localparam int unsigned ROW_W = $clog2(ROWS);
   localparam logic [1:0]  MAX_SEL = (ROUND_KEY_WORDS >= 60) ? 2'd2 :
                                     (ROUND_KEY_WORDS >= 52) ? 2'd1 : 2'd0;

   logic [63:0]  key_word_ff [4];
   logic [1:0]   key_length_ff;
   logic [1:0]   sel;
   logic [1:0]   sel_req;
   logic [3:0]   nk;
   logic [31:0]  win_ff [8];
   logic [2:0]   j_ff;
   logic [7:0]   rcon_ff;
   logic [31:0]  new_word;
   logic [31:0]  tmp;
   logic [63:0]  kw;
   logic         sched_word;
   logic [3:0][31:0] mem [ROWS];
   logic [127:0] rk_ff;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] ss;
   logic         valid_idx;

   // key registers
   always_comb begin
      unique case (csr_index)
         aes_pkg::CSR_KEY_WORD_0, aes_pkg::CSR_KEY_WORD_1, aes_pkg::CSR_KEY_WORD_2,
         aes_pkg::CSR_KEY_WORD_3, aes_pkg::CSR_KEY_LENGTH: valid_idx = 1'b1;
         default: valid_idx = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_word_ff[i] <= '0;
         key_length_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            aes_pkg::CSR_KEY_WORD_0: key_word_ff[0] <= csr_wdata;
            aes_pkg::CSR_KEY_WORD_1: key_word_ff[1] <= csr_wdata;
            aes_pkg::CSR_KEY_WORD_2: key_word_ff[2] <= csr_wdata;
            aes_pkg::CSR_KEY_WORD_3: key_word_ff[3] <= csr_wdata;
            aes_pkg::CSR_KEY_LENGTH: key_length_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // reserved length saturates; small store caps the length
   assign sel_req = (key_length_ff == aes_pkg::KEY_LEN_RSVD) ? aes_pkg::KEY_LEN_256
                                                             : key_length_ff;
   assign sel     = (sel_req > MAX_SEL) ? MAX_SEL : sel_req;
   assign nk      = 4'd4 + {1'b0, sel, 1'b0};

   assign status.cfg_written = csr_write_en && valid_idx;
   assign status.rounds      = nk + 4'd6;

   // key expansion, one word a cycle over an eight-word window
   assign sched_word = (cmd.exp_index >= aes_pkg::WORD_IDX_W'(nk));
   assign kw         = key_word_ff[cmd.exp_index[2:1]];

   always_comb begin
      tmp = win_ff[7];
      if (j_ff == 3'd0) begin
         tmp = aes_pkg::sub_word({win_ff[7][23:0], win_ff[7][31:24]}) ^ {rcon_ff, 24'h0};
      end else if ((nk == 4'd8) && (j_ff == 3'd4)) begin
         tmp = aes_pkg::sub_word(win_ff[7]);
      end
      if (sched_word) new_word = win_ff[3'd4 - {sel, 1'b0}] ^ tmp;
      else            new_word = cmd.exp_index[0] ? kw[31:0] : kw[63:32];
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_init) begin
         j_ff    <= '0;
         rcon_ff <= 8'h01;
      end else if (cmd.exp_step) begin
         j_ff <= (j_ff == 3'(nk - 4'd1)) ? 3'd0 : j_ff + 3'd1;
         if (sched_word && (j_ff == 3'd0)) rcon_ff <= aes_pkg::xtime(rcon_ff);
         for (int i = 0; i < 7; i++) win_ff[i] <= win_ff[i + 1];
         win_ff[7] <= new_word;
      end
   end

   // round key store, one word written, one row read per cycle
   always_ff @(posedge clock) begin
      if (cmd.exp_step)
         mem[cmd.exp_index[ROW_W+1:2]][2'd3 - cmd.exp_index[1:0]] <= new_word;
      rk_ff <= mem[cmd.rd_row[ROW_W-1:0]];
   end

   // round unit
   assign ss = aes_pkg::sub_shift(blk_ff, cmd.dec);

   always_comb begin
      blk_in = blk_ff;
      if (cmd.load) begin
         blk_in = {req_block_high, req_block_low};
      end else if (cmd.rnd_en) begin
         if (cmd.step == '0)                   blk_in = blk_ff ^ rk_ff;
         else if (cmd.step == status.rounds)  blk_in = ss ^ rk_ff;
         else if (cmd.dec)                     blk_in = aes_pkg::mix(ss ^ rk_ff, 1'b1);
         else                                  blk_in = aes_pkg::mix(ss, 1'b0) ^ rk_ff;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   assign rsp_result_high = blk_ff[127:64];
   assign rsp_result_low  = blk_ff[63:0];

endmodule

/* rtl/core/aes_block_cipher_core.sv */
// aes_block_cipher_core: top level of the AES-128/192/256 ECB core.
// Depends on aes_pkg, aes_ctrl, aes_dp.
//
// A block is taken when start is high and busy is low. With round keys
// already expanded, the result appears after the last round (Nr = 10, 12 or
// 14) on rsp_result_high/low for exactly one cycle, marked by rsp_strobe; the
// receiver cannot stall, so it must take the beat in that cycle. Busy falls
// in the strobe cycle, so the next block may be presented then and is taken
// at the edge that ends it; no new block is taken while one is in flight. The
// shared round unit does the initial key add and each of the Nr rounds, once
// state KEY0 has read the first round key from the key store.
// The first block after reset or any key register write first expands the
// key schedule, one word a cycle: 4*(Nr+1) words (44, 52 or 60). The user
// must write key registers through csr_* only while the core is idle; it is not enforced.
module aes_block_cipher_core #(
   parameter int unsigned ROUND_KEY_WORDS = 60
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_decrypt,
   input  logic [63:0]                     req_block_high,
   input  logic [63:0]                     req_block_low,
   output logic                            rsp_strobe,
   output logic [63:0]                     rsp_result_high,
   output logic [63:0]                     rsp_result_low,
   input  logic                            csr_write_en,
   input  logic [aes_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wdata
);

   aes_pkg::aes_cmd_type    cmd;
   aes_pkg::aes_status_type status;

   aes_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_decrypt (req_decrypt),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe)
   );

   aes_dp #(
      .ROUND_KEY_WORDS (ROUND_KEY_WORDS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_block_high  (req_block_high),
      .req_block_low   (req_block_low),
      .cmd             (cmd),
      .status          (status),
      .rsp_result_high (rsp_result_high),
      .rsp_result_low  (rsp_result_low)
   );

endmodule

/* sim/aes_block_cipher_core_tb.sv */
// aes_block_cipher_core_tb: self-checking bench for the AES ECB core.
// Depends on aes_pkg and aes_block_cipher_core; keeps its own cipher model
// and a scoreboard class that holds the expected result beats.
module aes_block_cipher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned KEY_STORE_WORDS = 60;
   localparam int unsigned IDLE_LIMIT      = 5000;
   localparam int unsigned RANDOM_BEATS    = 1530;

   // S-boxes held locally so the prediction does not lean on RTL functions
   localparam logic [7:0] SB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };
   localparam logic [7:0] RC [10] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_beat_type;

   // scoreboard: queue of expected result beats
   class cipher_scoreboard;
      cipher_beat_type pending[$];
      function void note_block(cipher_beat_type b);
         pending.push_back(b);
      endfunction
      task check_result(cipher_beat_type got);
         cipher_beat_type want;
         if (pending.size() == 0) begin
            report_mismatch("result beat with nothing expected", got, '0);
            return;
         end
         want = pending.pop_front();
         if (got.hi !== want.hi) report_mismatch("result_high", got, want);
         if (got.lo !== want.lo) report_mismatch("result_low", got, want);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_decrypt = 1'b0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_strobe;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_write_en = 1'b0;
   logic [aes_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   bit          idling_on = 1'b1;
   cipher_scoreboard sb = new();

   // predictor copy of the key registers and the expanded schedule
   logic [63:0] key_reg [4] = '{default: '0};
   logic [1:0]  key_len_reg = '0;
   logic [31:0] sched [KEY_STORE_WORDS];
   bit          sched_valid = 1'b0;
   int unsigned n_rounds = 10;

   always #5 clock = ~clock;

   aes_block_cipher_core u_top (.*);

   task automatic report_mismatch(string what, cipher_beat_type got, cipher_beat_type want);
      $display("mismatch %s: got %h_%h want %h_%h", what, got.hi, got.lo, want.hi, want.lo);
      fail_count++;
   endtask

   function automatic logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
      logic [7:0] acc;
      acc = '0;
      for (int n = 0; n < 8; n++) begin
         if (y[n]) acc ^= x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [31:0] sbox_word(logic [31:0] w);
      return {SB[w[31:24]], SB[w[23:16]], SB[w[15:8]], SB[w[7:0]]};
   endfunction

   // reserved length saturates to 256; 60 words always fit every length
   function automatic void build_schedule();
      int unsigned sel, nk, total;
      logic [31:0] t;
      sel = (key_len_reg > 2) ? 2 : key_len_reg;
      nk = 4 + 2 * sel;
      n_rounds = nk + 6;
      total = 4 * (n_rounds + 1);
      for (int i = 0; i < nk; i++)
         sched[i] = (i % 2) ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
      for (int i = nk; i < total; i++) begin
         t = sched[i-1];
         if (i % nk == 0)
            t = sbox_word({t[23:0], t[31:24]}) ^ {RC[i/nk-1], 24'h0};
         else if (nk > 6 && i % nk == 4)
            t = sbox_word(t);
         sched[i] = sched[i-nk] ^ t;
      end
      sched_valid = 1'b1;
   endfunction

   // state byte 4c+r lives at s[4c+r]
   function automatic cipher_beat_type cipher_block(logic dec, logic [63:0] hi,
                                                    logic [63:0] lo);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] inv_sb [256];
      logic [7:0] m [4];
      logic [7:0] acc;
      int unsigned src, rnd;
      cipher_beat_type out;
      for (int i = 0; i < 256; i++) inv_sb[SB[i]] = i[7:0];
      for (int i = 0; i < 8; i++) begin
         s[i]   = hi[63-8*i -: 8];
         s[8+i] = lo[63-8*i -: 8];
      end
      if (!sched_valid) build_schedule();
      if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int step = 0; step <= n_rounds; step++) begin
         rnd = dec ? n_rounds - step : step;
         if (step > 0) begin
            // substitute and shift rows
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  src = dec ? (c + 4 - r) % 4 : (c + r) % 4;
                  t[4*c+r] = dec ? inv_sb[s[4*src+r]] : SB[s[4*src+r]];
               end
            s = t;
            if (!dec && step < n_rounds) begin
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++) begin
                     acc = '0;
                     for (int k = 0; k < 4; k++) acc ^= gmul(m[(k+4-r)%4], s[4*c+k]);
                     t[4*c+r] = acc;
                  end
               s = t;
            end
         end
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               s[4*c+r] ^= sched[rnd*4+c][31-8*r -: 8];
         // inverse cipher mixes after the key add
         if (dec && step > 0 && step < n_rounds) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  acc = '0;
                  for (int k = 0; k < 4; k++) acc ^= gmul(m[(k+4-r)%4], s[4*c+k]);
                  t[4*c+r] = acc;
               end
            s = t;
         end
      end
      for (int i = 0; i < 8; i++) begin
         out.hi[63-8*i -: 8] = s[i];
         out.lo[63-8*i -: 8] = s[8+i];
      end
      return out;
   endfunction

   task automatic idle_burst();
      if (idling_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(negedge clock);
   endtask

   // one beat: hold start until the core takes it; driven at the falling edge
   task automatic send_block(logic dec, logic [63:0] hi, logic [63:0] lo);
      req_decrypt    = dec;
      req_block_high = hi;
      req_block_low  = lo;
      start          = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_block(cipher_block(dec, hi, lo));
      @(negedge clock);
      start = 1'b0;
   endtask

   // core idle: all results back, plus some slack
   task automatic wait_drained();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(logic [aes_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] val);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         aes_pkg::CSR_KEY_WORD_0, aes_pkg::CSR_KEY_WORD_1, aes_pkg::CSR_KEY_WORD_2,
         aes_pkg::CSR_KEY_WORD_3: key_reg[idx[1:0]] = val;
         aes_pkg::CSR_KEY_LENGTH: key_len_reg = val[1:0];
         default: return;   // out-of-range index is dropped, keys stay valid
      endcase
      sched_valid = 1'b0;
   endtask

   task automatic load_key(logic [1:0] len, logic [63:0] k0, logic [63:0] k1,
                           logic [63:0] k2, logic [63:0] k3);
      wait_drained();
      write_reg(aes_pkg::CSR_KEY_WORD_0, k0);
      write_reg(aes_pkg::CSR_KEY_WORD_1, k1);
      write_reg(aes_pkg::CSR_KEY_WORD_2, k2);
      write_reg(aes_pkg::CSR_KEY_WORD_3, k3);
      write_reg(aes_pkg::CSR_KEY_LENGTH, {62'b0, len});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // result beats are taken at the edge that ends the strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result('{rsp_result_high, rsp_result_low});
   end

   // watchdog: cycles with neither an input beat nor a result beat
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
         $display("aes_block_cipher_core_tb failed");
         $finish;
      end
   end

   initial begin
      logic [1:0] len;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset key (all zero, 128 bit), FIPS-197 vectors, extremes
      send_block(1'b0, '0, '0);
      send_block(1'b1, '1, '1);
      load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
      send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
      send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
      load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
      // reserved length saturates to 256 bit
      load_key(2'd3, '1, '1, '1, '1);
      send_block(1'b0, '1, '0);
      send_block(1'b1, '0, '1);
      // ignored index leaves the schedule in place
      wait_drained();
      write_reg(3'd7, '1);
      write_reg(3'd5, 64'h5a5a);
      send_block(1'b0, 64'h8000000000000000, 64'h1);
      // rewrite a single word mid-stream: forces re-expansion
      wait_drained();
      write_reg(aes_pkg::CSR_KEY_WORD_3, rand64());
      send_block(1'b1, rand64(), rand64());
      send_block(1'b0, rand64(), rand64());

      // random: key changes between bursts, random data and direction
      for (int b = 0; b < RANDOM_BEATS; b++) begin
         if (b % 40 == 0) begin
            len = 2'($urandom_range(0, 3));
            load_key(len, rand64(), rand64(), rand64(), rand64());
            if ($urandom_range(0, 3) == 0)
               write_reg(aes_pkg::CSR_INDEX_W'($urandom_range(5, 7)), rand64());
         end
         if (b >= RANDOM_BEATS - 150) idling_on = 1'b0;
         idle_burst();
         send_block(1'($urandom_range(0, 1)), rand64(), rand64());
      end

      wait_drained();
      if (sb.pending.size() != 0 || fail_count != 0)
         $display("aes_block_cipher_core_tb failed");
      else
         $display("aes_block_cipher_core_tb passed");
      $finish;
   end
endmodule
